FILE: sv/abpw_pkg.sv
// Shared types and constants of the alpha blending pixel writer.
package abpw_pkg;

	localparam int DEF_WIDTH   = 768;
	localparam int DEF_HEIGHT  = 576;
	localparam int QUEUE_DEPTH = 2;

	// Widest linear pixel index that any frame size within range can need.
	localparam int IDX_W = 24;

	localparam logic [7:0] T_COPY = 8'h00;
	localparam logic [7:0] T_KEEP = 8'hff;

	localparam logic [1:0] OP_CLIP  = 2'd0;
	localparam logic [1:0] OP_COPY  = 2'd1;
	localparam logic [1:0] OP_BLEND = 2'd2;
	localparam logic [1:0] OP_KEEP  = 2'd3;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  transparency;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pix_in_t;

	typedef struct packed {
		logic       written;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pix_out_t;

	// Classified write as it travels from the front end to the back end.
	// The color holds red, green and blue from the high byte down.
	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		logic [7:0]       t;
		logic [23:0]      color;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

FILE: sv/abpw_fifo.sv
// Small register based first-in first-out queue with a full and empty status.
module abpw_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = abpw_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DW-1:0]        wdata,
	input  logic                 pop,
	output logic [DW-1:0]        rdata,
	output abpw_pkg::fifo_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/abpw_front.sv
// Front end: takes pixel writes, clips them, computes the index and classifies them.
module abpw_front #(
	parameter int WIDTH  = abpw_pkg::DEF_WIDTH,
	parameter int HEIGHT = abpw_pkg::DEF_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  abpw_pkg::pix_in_t    item,
	input  logic                 clearing,
	input  abpw_pkg::fifo_stat_t q_stat,
	output logic                 q_push,
	output abpw_pkg::cmd_t       q_data
);

	localparam int PW = abpw_pkg::IDX_W + 1;

	logic           valid_s1;
	abpw_pkg::cmd_t cmd_s1;
	abpw_pkg::cmd_t cmd_d;
	logic           accept;
	logic           in_frame;
	logic [PW-1:0]  idx_full;

	assign full   = clearing || (valid_s1 && q_stat.full);
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_stat.full;
	assign q_data = cmd_s1;

	assign in_frame = ({1'b0, item.pos_x} < 13'(WIDTH)) && ({1'b0, item.pos_y} < 13'(HEIGHT));
	assign idx_full = PW'(item.pos_y) * PW'(WIDTH) + PW'(item.pos_x);

	always_comb begin
		cmd_d.idx   = in_frame ? idx_full[abpw_pkg::IDX_W-1:0] : '0;
		cmd_d.t     = item.transparency;
		cmd_d.color = {item.red, item.green, item.blue};
		if (!in_frame) begin
			cmd_d.op = abpw_pkg::OP_CLIP;
		end else if (item.transparency == abpw_pkg::T_COPY) begin
			cmd_d.op = abpw_pkg::OP_COPY;
		end else if (item.transparency == abpw_pkg::T_KEEP) begin
			cmd_d.op = abpw_pkg::OP_KEEP;
		end else begin
			cmd_d.op = abpw_pkg::OP_BLEND;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

FILE: sv/abpw_back.sv
// Back end: owns the frame store, clears it after reset and performs read-blend-write.
module abpw_back #(
	parameter int WIDTH  = abpw_pkg::DEF_WIDTH,
	parameter int HEIGHT = abpw_pkg::DEF_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 clearing,
	input  abpw_pkg::fifo_stat_t q_stat,
	input  abpw_pkg::cmd_t       q_data,
	output logic                 q_pop,
	input  abpw_pkg::fifo_stat_t o_stat,
	output logic                 o_push,
	output abpw_pkg::pix_out_t   o_data
);

	localparam int PIX_COUNT = WIDTH * HEIGHT;
	localparam int AW        = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;

	logic [23:0]    frame_q [PIX_COUNT];
	logic [1:0]     state_q;
	logic           clr_busy_q;
	logic [AW-1:0]  clr_addr_q;
	abpw_pkg::cmd_t cmd_q;
	logic [23:0]    rd_data_q;
	logic [15:0]    prod_old_q [3];
	logic [17:0]    prod_new_q [3];
	logic [23:0]    blended;
	logic [23:0]    new_color;
	logic           wr_en;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [23:0]    mem_wd;

	assign clearing = clr_busy_q;
	assign q_pop    = (state_q == ST_IDLE) && !clr_busy_q && !q_stat.empty && !o_stat.full;

	// One lane per color channel; products are registered before the sum.
	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [17:0] sum;
		assign sum = 18'(prod_old_q[c]) + prod_new_q[c];
		assign blended[8*c +: 8] = sum[15:8];

		always_ff @(posedge clk) begin
			if (state_q == ST_MUL) begin
				prod_old_q[c] <= 16'(rd_data_q[8*c +: 8]) * 16'(cmd_q.t);
				prod_new_q[c] <= (18'(cmd_q.color[8*c +: 8]) + 18'd1)
					* (18'd256 - 18'(cmd_q.t));
			end
		end
	end

	always_comb begin
		wr_en = cmd_q.op inside {abpw_pkg::OP_COPY, abpw_pkg::OP_BLEND};
		case (cmd_q.op)
			abpw_pkg::OP_COPY:  new_color = cmd_q.color;
			abpw_pkg::OP_BLEND: new_color = blended;
			abpw_pkg::OP_KEEP:  new_color = rd_data_q;
			default:            new_color = '0;
		endcase
	end

	assign o_push = (state_q == ST_WR);
	assign o_data = '{written: wr_en, out_red: new_color[23:16],
		out_green: new_color[15:8], out_blue: new_color[7:0]};

	assign mem_we = clr_busy_q || (o_push && wr_en);
	assign mem_wa = clr_busy_q ? clr_addr_q : cmd_q.idx[AW-1:0];
	assign mem_wd = clr_busy_q ? '0 : new_color;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_q[mem_wa] <= mem_wd;
		end
		if (q_pop) begin
			rd_data_q <= frame_q[q_data.idx[AW-1:0]];
			cmd_q     <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == AW'(PIX_COUNT - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: if (q_pop) begin
					state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_WR;
				ST_WR:   state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/alpha_blend_pixel_writer.sv
// Alpha blending pixel writer: the back end finishes one write, through its read, multiply
// and write-back sequence around its single frame store, before it takes the next.
// After reset the frame store is cleared to black, one pixel a cycle, for all WIDTH*HEIGHT
// pixels (442368 at the default size); full stays high until the clearing pass is done.
// All control state resets asynchronously on arst_n low.
module alpha_blend_pixel_writer #(
	parameter int WIDTH  = abpw_pkg::DEF_WIDTH,
	parameter int HEIGHT = abpw_pkg::DEF_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  abpw_pkg::pix_in_t  item,
	output logic               empty,
	input  logic               pop,
	output abpw_pkg::pix_out_t result
);

	localparam int CMD_W = $bits(abpw_pkg::cmd_t);
	localparam int OUT_W = $bits(abpw_pkg::pix_out_t);

	// Front end to command queue.
	logic                 q_push;
	abpw_pkg::cmd_t       q_wdata;
	logic                 q_pop;
	logic [CMD_W-1:0]     q_rdata;
	abpw_pkg::fifo_stat_t q_stat;

	// Back end to result queue.
	logic                 o_push;
	abpw_pkg::pix_out_t   o_wdata;
	logic [OUT_W-1:0]     o_rdata;
	abpw_pkg::fifo_stat_t o_stat;

	logic                 clearing;

	// The front end clips the write against the frame, forms the linear pixel index
	// and decides whether the transaction copies, blends, keeps or is dropped.
	abpw_front #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.clearing (clearing),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// The command queue decouples the front end from the back end so either may stall.
	abpw_fifo #(
		.DW    (CMD_W),
		.DEPTH (abpw_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (CMD_W'(q_wdata)),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// The back end works on one transaction at a time, so a later write to the same
	// pixel always reads the color stored by an earlier one.
	abpw_back #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.q_stat   (q_stat),
		.q_data   (abpw_pkg::cmd_t'(q_rdata)),
		.q_pop    (q_pop),
		.o_stat   (o_stat),
		.o_push   (o_push),
		.o_data   (o_wdata)
	);

	// Results wait here, so a stalled consumer does not hold up the back end at once.
	abpw_fifo #(
		.DW    (OUT_W),
		.DEPTH (abpw_pkg::QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (o_push),
		.wdata  (OUT_W'(o_wdata)),
		.pop    (pop),
		.rdata  (o_rdata),
		.stat   (o_stat)
	);

	assign empty  = o_stat.empty;
	assign result = abpw_pkg::pix_out_t'(o_rdata);

`ifndef SYNTHESIS
	// No transaction may enter while the frame store is still being cleared.
	a_full_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("write accepted during clearing pass");

	// The back end starts a transaction only when the result queue has room for it.
	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		o_push |-> !o_stat.full)
		else $error("result pushed into a full queue");

	// A command is taken only from a non-empty queue and never while clearing.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!q_stat.empty && !clearing))
		else $error("command popped from empty queue or during clearing");

	// Every command taken by the back end yields a result once it has passed the multiply state.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> ##1 o_push)
		else $error("back end did not produce a result");
`endif

endmodule

FILE: test/alpha_blend_pixel_writer_test.sv
// Self-checking testbench of the alpha blending pixel writer at its default frame size.
module alpha_blend_pixel_writer_test;
	timeunit 1ns;
	timeprecision 1ps;

	// The block runs at its default frame size. The clearing pass after reset takes
	// one cycle per pixel, which dominates the run but stays well under the limit.
	localparam int FRAME_W     = abpw_pkg::DEF_WIDTH;
	localparam int FRAME_H     = abpw_pkg::DEF_HEIGHT;
	localparam int CLEAR_CYCLES = FRAME_W * FRAME_H;
	// The slowest correct run is the clearing pass plus about 1650 transactions. Each one
	// can cost the block's read, multiply and write-back, a long sender gap and a long
	// receiver stall, and the limit leaves ample room for all of that.
	localparam int CYCLE_LIMIT = CLEAR_CYCLES + 2_000_000;
	localparam int DRAIN_LIMIT = 20_000;
	localparam int TAIL_CYCLES = 12;
	localparam int HOLD_CYCLES = 400;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               push   = 1'b0;
	logic               pop    = 1'b0;
	abpw_pkg::pix_in_t  item   = '0;
	logic               full;
	logic               empty;
	abpw_pkg::pix_out_t result;

	// Results still owed by the block, oldest first, and the predicted frame contents.
	// Pixels missing from the frame copy are still black from the clearing pass.
	abpw_pkg::pix_out_t pending_pixels[$];
	logic [23:0]        frame_copy[int unsigned];

	int push_idle_pct = 0;
	int pop_idle_pct  = 0;
	int stall_left    = 0;
	int fail_count    = 0;
	int checked_count = 0;
	int cycle_count   = 0;
	int op_count[4]   = '{default: 0};

	// The last position sent. Random writes revisit it so that back-to-back writes to
	// one pixel check that each one reads the color stored by the one before it.
	logic [11:0] last_x = '0;
	logic [11:0] last_y = '0;

	abpw_pkg::pix_out_t oldest_pixel;

	alpha_blend_pixel_writer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #2 clk = ~clk;

	// One channel of the blend. The sum never exceeds 16 bits for transparency 1 to 254.
	function automatic logic [7:0] blend_chan(input logic [7:0] old_v, input logic [7:0] new_v,
			input logic [7:0] t);
		int unsigned sum;
		sum = old_v * t + (new_v + 1) * (256 - t);
		return sum[15:8];
	endfunction

	// Applies one accepted write to the frame copy and returns the result it must cause.
	function automatic abpw_pkg::pix_out_t predict_pixel(input abpw_pkg::pix_in_t px);
		abpw_pkg::pix_out_t res;
		int unsigned        idx;
		logic [23:0]        cur;
		logic [1:0]         op;
		res = '0;
		if (px.pos_x >= FRAME_W || px.pos_y >= FRAME_H) begin
			op_count[abpw_pkg::OP_CLIP]++;
			return res;
		end
		idx = px.pos_y * FRAME_W + px.pos_x;
		cur = frame_copy.exists(idx) ? frame_copy[idx] : 24'h000000;
		if (px.transparency == abpw_pkg::T_COPY)
			op = abpw_pkg::OP_COPY;
		else if (px.transparency == abpw_pkg::T_KEEP)
			op = abpw_pkg::OP_KEEP;
		else
			op = abpw_pkg::OP_BLEND;
		case (op)
			abpw_pkg::OP_COPY: begin
				cur = {px.red, px.green, px.blue};
			end
			abpw_pkg::OP_BLEND: begin
				cur = {blend_chan(cur[23:16], px.red, px.transparency),
					blend_chan(cur[15:8], px.green, px.transparency),
					blend_chan(cur[7:0], px.blue, px.transparency)};
			end
			default: ;
		endcase
		op_count[op]++;
		if (op != abpw_pkg::OP_KEEP)
			frame_copy[idx] = cur;
		res.written   = (op != abpw_pkg::OP_KEEP);
		res.out_red   = cur[23:16];
		res.out_green = cur[15:8];
		res.out_blue  = cur[7:0];
		return res;
	endfunction

	// Offers one write and returns at the edge that accepts it. The valid stays high
	// from one transaction to the next unless the sender decides to idle first.
	task automatic send_pixel(input abpw_pkg::pix_in_t px);
		int gap;
		gap = 0;
		while ($urandom_range(99) < push_idle_pct)
			gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= px;
		do
			@(posedge clk);
		while (full);
		pending_pixels.push_back(predict_pixel(px));
		last_x = px.pos_x;
		last_y = px.pos_y;
	endtask

	task automatic send_fields(input int x, input int y, input int t, input logic [23:0] rgb);
		abpw_pkg::pix_in_t px;
		px.pos_x        = 12'(x);
		px.pos_y        = 12'(y);
		px.transparency = 8'(t);
		{px.red, px.green, px.blue} = rgb;
		send_pixel(px);
	endtask

	// Stops offering writes until every outstanding result has come back, with a bound
	// so that a lost result shows up as a leftover instead of a hang.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		push <= 1'b0;
		while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	function automatic logic [7:0] random_chan();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return 8'h00;
		if (pick < 20)
			return 8'hff;
		return 8'($urandom_range(255));
	endfunction

	// Random writes lean toward a few small regions so that pixels get blended many
	// times over, and toward the frame edges; a fifth use any 12-bit position at all.
	function automatic abpw_pkg::pix_in_t random_pixel();
		abpw_pkg::pix_in_t px;
		int unsigned       pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			px.pos_x = last_x;
			px.pos_y = last_y;
		end else if (pick < 50) begin
			px.pos_x = 12'($urandom_range(7));
			px.pos_y = 12'($urandom_range(3));
		end else if (pick < 65) begin
			px.pos_x = 12'($urandom_range(FRAME_W + 2, FRAME_W - 4));
			px.pos_y = 12'($urandom_range(FRAME_H + 1, FRAME_H - 3));
		end else if (pick < 80) begin
			px.pos_x = 12'($urandom_range(FRAME_W - 1));
			px.pos_y = 12'($urandom_range(FRAME_H - 1));
		end else begin
			px.pos_x = 12'($urandom_range(4095));
			px.pos_y = 12'($urandom_range(4095));
		end
		pick = $urandom_range(99);
		if (pick < 20)
			px.transparency = abpw_pkg::T_COPY;
		else if (pick < 35)
			px.transparency = abpw_pkg::T_KEEP;
		else if (pick < 40)
			px.transparency = 8'd1;
		else if (pick < 45)
			px.transparency = 8'd254;
		else
			px.transparency = 8'($urandom_range(255));
		px.red   = random_chan();
		px.green = random_chan();
		px.blue  = random_chan();
		return px;
	endfunction

	// Receiver side: checks each popped transaction against the oldest prediction, then
	// decides whether to pop on the next cycle. A requested hold-off is counted here.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_pixels.size() == 0) begin
				$error("result transaction with no write outstanding: %p", result);
				fail_count++;
			end else begin
				oldest_pixel = pending_pixels.pop_front();
				checked_count++;
				if (result.written !== oldest_pixel.written) begin
					$error("written: expected %0d, got %0d", oldest_pixel.written,
						result.written);
					fail_count++;
				end
				if (result.out_red !== oldest_pixel.out_red) begin
					$error("out_red: expected %0d, got %0d", oldest_pixel.out_red,
						result.out_red);
					fail_count++;
				end
				if (result.out_green !== oldest_pixel.out_green) begin
					$error("out_green: expected %0d, got %0d", oldest_pixel.out_green,
						result.out_green);
					fail_count++;
				end
				if (result.out_blue !== oldest_pixel.out_blue) begin
					$error("out_blue: expected %0d, got %0d", oldest_pixel.out_blue,
						result.out_blue);
					fail_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= pop_idle_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Pixels never written must read back black after the clearing pass. A fully
	// transparent write reports the stored color without writing.
	task automatic test_cleared_frame();
		send_fields(0, 0, abpw_pkg::T_KEEP, 24'hffffff);
		send_fields(FRAME_W - 1, FRAME_H - 1, abpw_pkg::T_KEEP, 24'h123456);
		send_fields(FRAME_W / 2, FRAME_H / 2, abpw_pkg::T_KEEP, 24'h000000);
	endtask

	// Positions just past each edge and at the top of the 12-bit range are dropped,
	// and the result is all zero whatever the transparency.
	task automatic test_clipping();
		send_fields(FRAME_W, 0, abpw_pkg::T_COPY, 24'hffffff);
		send_fields(0, FRAME_H, 8'd77, 24'haa55aa);
		send_fields(4095, 4095, abpw_pkg::T_KEEP, 24'hffffff);
		send_fields(FRAME_W - 1, FRAME_H, abpw_pkg::T_COPY, 24'h0f0f0f);
		send_fields(FRAME_W, FRAME_H - 1, 8'd254, 24'hf0f0f0);
	endtask

	// Copies at the corners with both extreme colors, then read back without writing.
	task automatic test_copy();
		send_fields(0, 0, abpw_pkg::T_COPY, 24'hffffff);
		send_fields(FRAME_W - 1, FRAME_H - 1, abpw_pkg::T_COPY, 24'h000000);
		send_fields(FRAME_W - 1, 0, abpw_pkg::T_COPY, 24'h8040c0);
		send_fields(0, 0, abpw_pkg::T_KEEP, 24'h000000);
	endtask

	// Blends at the transparency extremes and midway, back to back on each of two pixels,
	// so that each blend reads the color that the write just before it produced.
	task automatic test_blend();
		send_fields(1, 1, abpw_pkg::T_COPY, 24'hffffff);
		send_fields(1, 1, 8'd1, 24'hffffff);
		send_fields(1, 1, 8'd254, 24'h000000);
		send_fields(5, 5, abpw_pkg::T_COPY, 24'hc86432);
		send_fields(5, 5, 8'd128, 24'h00ff80);
		send_fields(5, 5, abpw_pkg::T_KEEP, 24'hffffff);
	endtask

	task automatic test_random_writes(input int count, input int send_pct, input int recv_pct);
		push_idle_pct = send_pct;
		pop_idle_pct  = recv_pct;
		repeat (count)
			send_pixel(random_pixel());
	endtask

	// The receiver holds off for a long stretch while writes keep coming, so the
	// block fills and must stall its input; afterwards the sender waits for it to drain.
	task automatic test_backpressure();
		push_idle_pct = 0;
		pop_idle_pct  = 0;
		stall_left    = HOLD_CYCLES;
		repeat (40)
			send_pixel(random_pixel());
		wait_for_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_cleared_frame();
		test_clipping();
		test_copy();
		test_blend();
		wait_for_results();

		test_random_writes(500, 18, 84);
		test_backpressure();
		test_random_writes(500, 84, 18);
		wait_for_results();
		test_random_writes(600, 0, 0);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$error("%0d results never arrived", pending_pixels.size());
			fail_count++;
		end

		$display("Checked %0d transactions: %0d copies, %0d blends, %0d kept, %0d clipped.",
			checked_count, op_count[abpw_pkg::OP_COPY], op_count[abpw_pkg::OP_BLEND],
			op_count[abpw_pkg::OP_KEEP], op_count[abpw_pkg::OP_CLIP]);
		$display("Idling was varied on both sides, with one long receiver hold-off.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
